FILE: src/wdt_pkg.sv
// ----------------------------------------------------------------------------
// wdt_pkg
// Shared types, codes and defaults for the multi-channel watchdog table.
// ----------------------------------------------------------------------------
package wdt_pkg;

    // default table size and config reset value
    localparam int          CHANNELS_DEF = 256;
    localparam logic [13:0] TPS_RESET    = 14'd100;

    // action codes
    localparam logic [2:0] ACT_REGISTER   = 3'd0;
    localparam logic [2:0] ACT_UNREGISTER = 3'd1;
    localparam logic [2:0] ACT_UPDATE     = 3'd2;
    localparam logic [2:0] ACT_CHECK      = 3'd3;
    localparam logic [2:0] ACT_CLEAR      = 3'd4;

    // channel modes
    localparam logic [1:0] MODE_RUNNING   = 2'd0;
    localparam logic [1:0] MODE_SUSPENDED = 2'd1;
    localparam logic [1:0] MODE_EXITED    = 2'd2;
    localparam logic [1:0] MODE_DEAD      = 2'd3;

    // result status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;
    localparam logic [1:0] ST_NONE    = 2'd3;

    // one table entry as held in the memory
    typedef struct packed {
        logic        in_use;
        logic        expired;
        logic [1:0]  mode;
        logic [7:0]  timeout;
        logic [31:0] feed;
        logic [15:0] tag;
    } wdt_entry_t;

    localparam int ENTRY_W = $bits(wdt_entry_t);

    // captured input item
    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] now;
        logic [7:0]  tsec;
        logic [15:0] tag;
        logic [1:0]  mode;
    } wdt_item_t;

    // per-entry decision from the evaluation unit
    typedef struct packed {
        logic       valid;
        logic       hit;
        logic       wr_en;
        wdt_entry_t wr_data;
        logic [15:0] hit_tag;
    } wdt_dec_t;

endpackage

FILE: src/wdt_ram.sv
// ----------------------------------------------------------------------------
// wdt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module wdt_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/wdt_eval.sv
// ----------------------------------------------------------------------------
// wdt_eval
// Two-stage per-entry evaluation: registers the entry and its timeout limit,
// then decides hit and write-back for the current action.
// ----------------------------------------------------------------------------
module wdt_eval #(
    parameter  int CHANNELS = wdt_pkg::CHANNELS_DEF,
    localparam int AW       = $clog2(CHANNELS)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                flush,
    input  logic                rd_valid,
    input  logic [AW-1:0]       rd_idx,
    input  wdt_pkg::wdt_entry_t rd_entry,
    input  wdt_pkg::wdt_item_t  item,
    input  logic [13:0]         tps,
    output wdt_pkg::wdt_dec_t   dec,
    output logic [AW-1:0]       dec_idx
);
    import wdt_pkg::*;

    logic       a_valid_reg;
    logic [AW-1:0] a_idx_reg;
    wdt_entry_t a_entry_reg;
    logic [21:0] a_prod_reg;

    logic [31:0] limit;
    logic [31:0] feed_eff;
    logic        wrapped;
    logic        eligible;
    logic        expire;
    wdt_entry_t  e;

    // stage A control
    always_ff @(posedge aclk) begin
        if (!aresetn || flush) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= rd_valid;
        end
    end

    // stage A payload: entry and timeout * ticks-per-second
    always_ff @(posedge aclk) begin
        a_idx_reg   <= rd_idx;
        a_entry_reg <= rd_entry;
        a_prod_reg  <= 22'(rd_entry.timeout) * 22'(tps);
    end

    // expiry test
    always_comb begin
        e        = a_entry_reg;
        limit    = 32'(a_prod_reg);
        wrapped  = item.now < e.feed;
        feed_eff = wrapped ? 32'd0 : e.feed;
        eligible = e.in_use && !e.expired &&
                   (e.mode != MODE_SUSPENDED) && (e.mode != MODE_EXITED);
        expire   = eligible && (item.now >= limit) && ((item.now - feed_eff) > limit);
    end

    // decision and write-back data per action
    always_comb begin
        dec         = '0;
        dec.valid   = a_valid_reg;
        dec.hit_tag = e.tag;
        dec.wr_data = e;
        case (item.action)
            ACT_REGISTER: begin
                dec.hit             = !e.in_use;
                dec.wr_en           = !e.in_use;
                dec.wr_data.in_use  = 1'b1;
                dec.wr_data.expired = 1'b0;
                dec.wr_data.mode    = MODE_RUNNING;
                dec.wr_data.timeout = item.tsec;
                dec.wr_data.feed    = item.now;
                dec.wr_data.tag     = item.tag;
            end
            ACT_UNREGISTER: begin
                dec.hit            = e.in_use;
                dec.wr_en          = e.in_use;
                dec.wr_data.in_use = 1'b0;
            end
            ACT_UPDATE: begin
                dec.hit          = e.in_use && !e.expired;
                dec.wr_en        = e.in_use && !e.expired;
                dec.wr_data.feed = item.now;
                dec.wr_data.mode = item.mode;
            end
            ACT_CHECK: begin
                dec.hit          = expire;
                dec.wr_en        = expire || (eligible && wrapped);
                dec.wr_data.feed = feed_eff;
                if (expire) begin
                    dec.wr_data.expired = 1'b1;
                    dec.wr_data.mode    = MODE_DEAD;
                end
            end
            default: begin
                dec.hit   = 1'b0;
                dec.wr_en = 1'b0;
            end
        endcase
        if (!a_valid_reg) begin
            dec.hit   = 1'b0;
            dec.wr_en = 1'b0;
        end
    end

    assign dec_idx = a_idx_reg;

endmodule

FILE: src/multi_channel_watchdog_table_top.sv
// Flow: register and check read one entry per cycle, then pass it through two evaluation
//   stages; unregister and update read only the given slot; clear sweeps the whole table;
//   an unknown action or an out-of-range slot goes straight to the result.
// Throughput: one item at a time; the next input is taken in the cycle after the result
//   register loads, and a stalled result register holds the sequencer in its last state.
// Reset: synchronous; a pass then zeroes the table RAM with s_ready low.
// ----------------------------------------------------------------------------
// multi_channel_watchdog_table_top
// Watchdog channel table kept in one RAM, with scan sequencer and result
// register.
// ----------------------------------------------------------------------------
module multi_channel_watchdog_table_top #(
    parameter int CHANNELS = wdt_pkg::CHANNELS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config
    input  logic        cfg_wr_en,
    input  logic [13:0] cfg_wr_data,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_action,
    input  logic [31:0] s_now_tick,
    input  logic [7:0]  s_timeout_sec,
    input  logic [15:0] s_user_tag,
    input  logic [7:0]  s_slot,
    input  logic [1:0]  s_new_mode,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [7:0]  m_slot_out,
    output logic [15:0] m_tag_out,
    output logic [8:0]  m_active_count
);
    import wdt_pkg::*;

    localparam int AW = $clog2(CHANNELS);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_CLEAR = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0]    state_reg, state_next;
    wdt_item_t     item_reg, item_next;
    logic [AW-1:0] slot_idx_reg, slot_idx_next;
    logic          single_reg, single_next;
    logic [AW:0]   iss_cnt_reg, iss_cnt_next;
    logic          rd_valid_reg, rd_valid_next;
    logic [AW-1:0] rd_idx_reg;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [8:0]    used_reg, used_next;
    logic [13:0]   tps_reg;
    logic [1:0]    res_status_reg, res_status_next;
    logic [7:0]    res_slot_reg, res_slot_next;
    logic [15:0]   res_tag_reg, res_tag_next;
    logic          m_valid_reg, m_valid_next;
    logic [1:0]    m_status_reg;
    logic [7:0]    m_slot_reg;
    logic [15:0]   m_tag_reg;
    logic [8:0]    m_count_reg;
    logic          m_load;

    // RAM and evaluation wiring
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    wdt_entry_t    ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    wdt_entry_t    ram_rd_data;
    wdt_dec_t      dec;
    logic [AW-1:0] dec_idx;
    logic          hit_now;
    logic [AW:0]   limit;
    logic          slot_ok;
    logic          clearing;

    wdt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CHANNELS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    wdt_eval #(
        .CHANNELS (CHANNELS)
    ) u_eval (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .flush    (hit_now),
        .rd_valid (rd_valid_reg),
        .rd_idx   (rd_idx_reg),
        .rd_entry (ram_rd_data),
        .item     (item_reg),
        .tps      (tps_reg),
        .dec      (dec),
        .dec_idx  (dec_idx)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign clearing = (state_reg == S_INIT) || (state_reg == S_CLEAR);
    assign hit_now  = (state_reg == S_SCAN) && dec.hit;
    assign limit    = single_reg ? (AW+1)'(1) : (AW+1)'(CHANNELS);
    assign slot_ok  = 32'(s_slot) < 32'(CHANNELS);

    // read issue: one entry per cycle until the range is done or a hit stops it
    assign ram_rd_en   = (state_reg == S_SCAN) && (iss_cnt_reg != limit) && !hit_now;
    assign ram_rd_addr = single_reg ? slot_idx_reg : iss_cnt_reg[AW-1:0];

    // write port: clearing sweep or write-back from evaluation
    assign ram_wr_en   = clearing || ((state_reg == S_SCAN) && dec.wr_en);
    assign ram_wr_addr = clearing ? clr_cnt_reg : dec_idx;
    assign ram_wr_data = clearing ? wdt_entry_t'('0) : dec.wr_data;

    // result register is free when empty or being taken now
    assign m_load = (state_reg == S_FIN) && (!m_valid_reg || m_ready);

    // sequencer
    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        slot_idx_next   = slot_idx_reg;
        single_next     = single_reg;
        iss_cnt_next    = iss_cnt_reg;
        rd_valid_next   = ram_rd_en;
        clr_cnt_next    = clr_cnt_reg;
        used_next       = used_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_tag_next    = res_tag_reg;
        if (ram_rd_en) begin
            iss_cnt_next = iss_cnt_reg + (AW+1)'(1);
        end
        case (state_reg)
            S_INIT, S_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(CHANNELS - 1)) begin
                    clr_cnt_next = '0;
                    if (state_reg == S_CLEAR) begin
                        used_next       = '0;
                        res_status_next = ST_DONE;
                        state_next      = S_FIN;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    item_next.action = s_action;
                    item_next.now    = s_now_tick;
                    item_next.tsec   = s_timeout_sec;
                    item_next.tag    = s_user_tag;
                    item_next.mode   = s_new_mode;
                    slot_idx_next    = AW'(s_slot);
                    iss_cnt_next     = '0;
                    res_status_next  = ST_IGNORED;
                    res_slot_next    = '0;
                    res_tag_next     = '0;
                    case (s_action)
                        ACT_REGISTER, ACT_CHECK: begin
                            single_next = 1'b0;
                            state_next  = S_SCAN;
                        end
                        ACT_UNREGISTER, ACT_UPDATE: begin
                            single_next = 1'b1;
                            state_next  = slot_ok ? S_SCAN : S_FIN;
                        end
                        ACT_CLEAR: begin
                            clr_cnt_next = '0;
                            state_next   = S_CLEAR;
                        end
                        default: begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (hit_now) begin
                    rd_valid_next   = 1'b0;
                    res_status_next = ST_DONE;
                    if (item_reg.action == ACT_REGISTER) begin
                        res_slot_next = 8'(dec_idx);
                        used_next     = used_reg + 9'd1;
                    end else if (item_reg.action == ACT_CHECK) begin
                        res_slot_next = 8'(dec_idx);
                        res_tag_next  = dec.hit_tag;
                    end else if (item_reg.action == ACT_UNREGISTER) begin
                        used_next = used_reg - 9'd1;
                    end
                    state_next = S_FIN;
                end else if ((iss_cnt_reg == limit) && !rd_valid_reg && !dec.valid) begin
                    if (item_reg.action == ACT_REGISTER) begin
                        res_status_next = ST_FULL;
                    end else if (item_reg.action == ACT_CHECK) begin
                        res_status_next = ST_NONE;
                    end else begin
                        res_status_next = ST_IGNORED;
                    end
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (m_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result register handshake
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_INIT;
            clr_cnt_reg  <= '0;
            iss_cnt_reg  <= '0;
            rd_valid_reg <= 1'b0;
            single_reg   <= 1'b0;
            used_reg     <= '0;
            m_valid_reg  <= 1'b0;
            tps_reg      <= TPS_RESET;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            iss_cnt_reg  <= iss_cnt_next;
            rd_valid_reg <= rd_valid_next;
            single_reg   <= single_next;
            used_reg     <= used_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                tps_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        item_reg       <= item_next;
        slot_idx_reg   <= slot_idx_next;
        rd_idx_reg     <= ram_rd_addr;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_tag_reg    <= res_tag_next;
        if (m_load) begin
            m_status_reg <= res_status_reg;
            m_slot_reg   <= res_slot_reg;
            m_tag_reg    <= res_tag_reg;
            m_count_reg  <= used_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_slot_out     = m_slot_reg;
    assign m_tag_out      = m_tag_reg;
    assign m_active_count = m_count_reg;

endmodule

FILE: src/wdt_checker.sv
// ----------------------------------------------------------------------------
// wdt_checker
// Port-level checks on the watchdog table, bound to the top level.
// ----------------------------------------------------------------------------
module wdt_checker #(
    parameter int CHANNELS = wdt_pkg::CHANNELS_DEF
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic [7:0]  m_slot_out,
    input logic [15:0] m_tag_out,
    input logic [8:0]  m_active_count
);
    import wdt_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_slot_out)
                                && $stable(m_tag_out) && $stable(m_active_count))
        else $error("result changed while stalled");

    // table full is reported only with every channel in use
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_FULL) |-> (m_active_count == 9'(CHANNELS)))
        else $error("full status with free channels");

    // failed outcomes carry no slot and no tag
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_DONE) |-> (m_slot_out == 8'd0) && (m_tag_out == 16'd0))
        else $error("slot or tag on a failed result");

    // clearing pass after reset blocks input
    a_init_block: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) == 1'b0) |-> !s_ready)
        else $error("input taken during clearing pass");

endmodule

bind multi_channel_watchdog_table_top wdt_checker #(.CHANNELS(CHANNELS)) u_wdt_checker (.*);
